// ===== rtl/sorted_max_priority_queue_assert.svh =====
// Assertion macros shared by the sorted max priority queue RTL.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef SORTED_MAX_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_MAX_PRIORITY_QUEUE_ASSERT_SVH

// Checked on every rising edge outside reset.
`define SMPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SMPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/smpq_pkg.sv =====
// Shared types and constants for the sorted max priority queue.
// No dependencies; imported by smpq_cell and sorted_max_priority_queue.
package smpq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int LIMIT_W   = 5;
    localparam int COUNT_OUT_W = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic               push_en;
        logic               pop_en;
        logic [VALUE_W-1:0] push_value;
    } smpq_ctrl_t;

endpackage

// ===== rtl/smpq_cell.sv =====
// One storage cell of the sorted chain: holds one entry and trades it with its neighbors.
// Depends on smpq_pkg.
module smpq_cell
    import smpq_pkg::*;
(
    input  logic               clk,
    input  smpq_ctrl_t         ctrl,
    input  logic               occupied,
    input  logic [VALUE_W-1:0] left_value,
    input  logic               left_ge,
    input  logic [VALUE_W-1:0] right_value,
    output logic [VALUE_W-1:0] value,
    output logic [VALUE_W-1:0] value_next,
    output logic               ge
);

    logic [VALUE_W-1:0] value_reg;

    // The entry stays ahead of the new word when it is at least as large.
    assign ge = occupied && ($signed(value_reg) >= $signed(ctrl.push_value));

    always_comb
    begin
        value_next = value_reg;
        priority if (ctrl.push_en)
        begin
            if (ge)
                value_next = value_reg;
            else if (left_ge)
                value_next = ctrl.push_value;
            else
                value_next = left_value;
        end
        else if (ctrl.pop_en)
        begin
            value_next = right_value;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== rtl/sorted_max_priority_queue.sv =====
// Top level of the sorted max priority queue: controller, output register and cell chain.
// Depends on smpq_pkg, smpq_cell and sorted_max_priority_queue_assert.svh.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_stall   cmd, push_value
//   output    out        out_valid / out_stall status, removed_value, top_value,
//                                              bottom_value, entry_count,
//                                              empty_flag, full_flag
//   config    in         cfg_wr_en             cfg_wr_data (capacity limit)
//
// Each accepted word updates the whole chain in the cycle it is accepted, and its
// result word is registered at that same edge, so one word per cycle is sustained
// while the output is not stalled; output valid rises in the cycle after acceptance.
// Reset empties the queue and restores a capacity limit of 16; the entries
// themselves are not cleared, since only the first entry_count cells are ever read.
// The input is stalled only while a result word waits in the output register and
// the output side stalls it.

`include "sorted_max_priority_queue_assert.svh"

module sorted_max_priority_queue
    import smpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_wr_en,
    input  logic [LIMIT_W-1:0]        cfg_wr_data,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      cmd,
    input  logic signed [VALUE_W-1:0] push_value,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic signed [VALUE_W-1:0] removed_value,
    output logic signed [VALUE_W-1:0] top_value,
    output logic signed [VALUE_W-1:0] bottom_value,
    output logic [COUNT_OUT_W-1:0]    entry_count,
    output logic                      empty_flag,
    output logic                      full_flag
);

    // Count width holds 0..DEPTH; compare width also fits the 5-bit limit.
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int IW = $clog2(DEPTH);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] limit_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [VALUE_W-1:0] bottom_reg;
    logic [VALUE_W-1:0] bottom_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    // Result word register.
    logic [1:0]         status_reg;
    logic [VALUE_W-1:0] removed_reg;
    logic [VALUE_W-1:0] top_reg;
    logic [VALUE_W-1:0] bottom_out_reg;
    logic [CW-1:0]      count_out_reg;
    logic               empty_reg;
    logic               full_reg;

    logic               in_fire;
    logic               push_ok;
    logic               pop_ok;
    logic [LW-1:0]      limit_ext;
    logic [LW-1:0]      depth_ext;
    logic [LW-1:0]      cap;
    logic [LW-1:0]      count_ext;
    logic [LW-1:0]      count_next_ext;
    logic [LW-1:0]      count_out_ext;
    status_t            status_next;

    smpq_ctrl_t         ctrl;
    logic [VALUE_W-1:0] cell_value      [DEPTH];
    logic [VALUE_W-1:0] cell_value_next [DEPTH];
    logic [DEPTH-1:0]   cell_ge;
    logic [DEPTH-1:0]   cell_occ;

    // A new word is taken unless a finished result is held back downstream.
    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    // Limit in force is the written limit, clipped to the physical depth.
    assign limit_ext = LW'(limit_reg);
    assign depth_ext = LW'(DEPTH);
    assign cap       = (limit_ext > depth_ext) ? depth_ext : limit_ext;
    assign count_ext = LW'(count_reg);

    assign push_ok = in_fire && (cmd == CMD_PUSH) && (count_ext < cap);
    assign pop_ok  = in_fire && (cmd == CMD_POP) && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        priority if (push_ok)
            count_next = count_reg + 1'b1;
        else if (pop_ok)
            count_next = count_reg - 1'b1;
        else
            count_next = count_reg;
    end

    assign count_next_ext = LW'(count_next);

    // The smallest entry is tracked beside the chain. A push lands at the tail
    // only when no held entry is smaller than it; a pop never touches the tail.
    always_comb
    begin
        bottom_next = bottom_reg;
        if (push_ok && ((count_reg == '0) || ($signed(bottom_reg) >= $signed(push_value))))
            bottom_next = push_value;
    end

    always_comb
    begin
        status_next = ST_DONE;
        if (in_fire && (cmd == CMD_PUSH) && !push_ok)
            status_next = ST_FULL;
        else if (in_fire && (cmd == CMD_POP) && !pop_ok)
            status_next = ST_EMPTY;
    end

    // ------------------------------------------------------------------
    // Cell chain: cell 0 holds the largest entry.
    // ------------------------------------------------------------------
    assign ctrl.push_en    = push_ok;
    assign ctrl.pop_en     = pop_ok;
    assign ctrl.push_value = push_value;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_W-1:0] left_value;
        logic               left_ge;
        logic [VALUE_W-1:0] right_value;

        assign cell_occ[i] = (count_reg > CW'(i));

        if (i == 0)
        begin : g_head
            // Nothing stands ahead of the head cell.
            assign left_value = '0;
            assign left_ge    = 1'b1;
        end
        else
        begin : g_body
            assign left_value = cell_value[i-1];
            assign left_ge    = cell_ge[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
        end

        smpq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (cell_occ[i]),
            .left_value  (left_value),
            .left_ge     (left_ge),
            .right_value (right_value),
            .value       (cell_value[i]),
            .value_next  (cell_value_next[i]),
            .ge          (cell_ge[i])
        );
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    assign out_valid_next = in_fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bottom_reg <= bottom_next;
        if (in_fire)
        begin
            status_reg     <= status_next;
            removed_reg    <= pop_ok ? cell_value[0] : '0;
            top_reg        <= (count_next == '0) ? '0 : cell_value_next[0];
            bottom_out_reg <= (count_next == '0) ? '0 : bottom_next;
            count_out_reg  <= count_next;
            empty_reg      <= (count_next == '0);
            full_reg       <= (count_next_ext >= cap);
        end
    end

    assign count_out_ext = LW'(count_out_reg);

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign top_value     = top_reg;
    assign bottom_value  = bottom_out_reg;
    assign entry_count   = count_out_ext[COUNT_OUT_W-1:0];
    assign empty_flag    = empty_reg;
    assign full_flag     = full_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic head_in_order;
    logic bottom_matches;

    assign head_in_order  = $signed(cell_value[0]) >= $signed(cell_value[1]);
    assign bottom_matches = (bottom_reg == cell_value[IW'(count_reg - 1'b1)]);

    `SMPQ_ASSERT(a_count_bound, count_ext <= depth_ext, "count exceeds depth")
    `SMPQ_ASSERT(a_push_grows, push_ok |=> count_reg == $past(count_reg) + 1'b1, "push lost")
    `SMPQ_ASSERT(a_head_sorted, count_reg >= CW'(2) |-> head_in_order, "head out of order")
    `SMPQ_ASSERT(a_bottom_track, count_reg != '0 |-> bottom_matches, "bottom mismatch")

endmodule
